// ===== design/insert_shift_array_defines.svh =====
// ----------------------------------------------------------------------------
// insert_shift_array assertion macros
// Concurrent assertion wrappers shared by the insert_shift_array RTL.
// ----------------------------------------------------------------------------
`ifndef INSERT_SHIFT_ARRAY_DEFINES_SVH
`define INSERT_SHIFT_ARRAY_DEFINES_SVH

// implication checked on every rising clock edge, off while in reset
`define IAS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("insert_shift_array assertion failed");

// condition that must never hold while out of reset
`define IAS_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("insert_shift_array assertion failed");

`endif

// ===== design/ias_pkg.sv =====
// ----------------------------------------------------------------------------
// ias_pkg
// Request/response word types, request codes and the cell control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ias_pkg;

  localparam int unsigned IDX_W  = 10;
  localparam int unsigned DATA_W = 32;

  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_INSERT = 2'd2;
  // unused code: no effect, no result
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_NOTICE = 1'b1;

  typedef struct packed {
    logic [1:0]               req_type;
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] value;
  } ias_req_t;

  typedef struct packed {
    logic                     kind;
    logic signed [DATA_W-1:0] data;
  } ias_rsp_t;

  // broadcast to every cell during the update cycle
  typedef struct packed {
    logic                     exec;
    logic                     wr;
    logic                     ins;
    logic                     shift;
    logic signed [DATA_W-1:0] word;
  } ias_ctl_t;

endpackage

// ===== design/ias_cell.sv =====
// ----------------------------------------------------------------------------
// ias_cell
// One slot of the array: holds a word, joins the scan chains and takes its
// neighbor's word on a shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ias_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              take_i,
  input  ias_pkg::ias_ctl_t                 ctl_i,
  input  logic                              hit_i,
  input  logic                              gt_i,
  output logic                              gt_o,
  input  logic signed [ias_pkg::DATA_W-1:0] rd_i,
  output logic signed [ias_pkg::DATA_W-1:0] rd_o,
  input  logic                              hocc_i,
  output logic                              hocc_o,
  input  logic                              sfx_i,
  output logic                              sfx_o,
  input  logic                              prev_occ_i,
  input  logic signed [ias_pkg::DATA_W-1:0] prev_data_i,
  output logic signed [ias_pkg::DATA_W-1:0] data_o,
  output logic                              occ_o
);
  import ias_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     hit_q, gt_q, app_q;
  logic                     occ, app;

  assign occ    = (data_q != '0);
  assign occ_o  = occ;
  assign data_o = data_q;

  // upward chains: read data, addressed-slot occupancy, above-slot flag
  assign rd_o   = rd_i | (hit_i ? data_q : '0);
  assign hocc_o = hocc_i | (hit_i & occ);
  assign gt_o   = gt_i | hit_i;
  // downward chain: anything occupied at or above this slot
  assign sfx_o  = sfx_i | occ;
  // first empty slot just above the highest occupied one
  assign app    = prev_occ_i & ~sfx_o;

  always_comb begin
    data_d = data_q;
    if (ctl_i.exec) begin
      if (ctl_i.wr && hit_q) begin
        data_d = ctl_i.word;
      end else if (ctl_i.ins && ctl_i.shift) begin
        if (hit_q) begin
          data_d = ctl_i.word;
        end else if (gt_q) begin
          data_d = prev_data_i;
        end
      end else if (ctl_i.ins && app_q) begin
        data_d = ctl_i.word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
      hit_q  <= 1'b0;
      gt_q   <= 1'b0;
      app_q  <= 1'b0;
    end else begin
      data_q <= data_d;
      if (take_i) begin
        hit_q <= hit_i;
        gt_q  <= gt_i;
        app_q <= app;
      end
    end
  end

endmodule

// ===== design/insert_shift_array.sv =====
// A result (read data, or notice of an in-range write to an empty slot)
//   strobes on valid_o in the cycle right after the accepting edge.
// No request is taken while busy; busy is high for the single
//   update cycle in which every cell of the chain loads its new word.
// Reset: asynchronous, clears every slot to zero (empty) at once, no sweep.
// ----------------------------------------------------------------------------
// insert_shift_array
// Array of signed words kept in a row of cells; read, write and insert
// with shift-up or append above the highest occupied slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "insert_shift_array_defines.svh"

module insert_shift_array #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ias_pkg::ias_req_t req_i,
  output logic              valid_o,
  output ias_pkg::ias_rsp_t rsp_o
);
  import ias_pkg::*;

  logic                     accept;
  logic                     in_range;
  logic [DEPTH-1:0]         hit;
  logic [DEPTH:0]           gt_c, hocc_c, sfx_c;
  logic signed [DATA_W-1:0] rd_c   [DEPTH+1];
  logic signed [DATA_W-1:0] data_w [DEPTH];
  logic [DEPTH-1:0]         occ_w;
  logic                     slot_occ;
  ias_ctl_t                 ctl_q;
  ias_rsp_t                 rsp_q;
  logic                     valid_q;

  assign accept   = start & ~busy;
  assign busy     = ctl_q.exec;
  assign in_range = (32'(req_i.index) < 32'(DEPTH));
  assign gt_c[0]  = 1'b0;
  assign hocc_c[0] = 1'b0;
  assign rd_c[0]  = '0;
  assign sfx_c[DEPTH] = 1'b0;
  assign slot_occ = hocc_c[DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                     prev_occ;
    logic signed [DATA_W-1:0] prev_data;

    assign hit[g] = (32'(req_i.index) == 32'(g));

    if (g == 0) begin : g_first
      // empty array appends at slot 0
      assign prev_occ  = 1'b1;
      assign prev_data = '0;
    end else begin : g_rest
      assign prev_occ  = occ_w[g-1];
      assign prev_data = data_w[g-1];
    end

    ias_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .take_i      (accept),
      .ctl_i       (ctl_q),
      .hit_i       (hit[g]),
      .gt_i        (gt_c[g]),
      .gt_o        (gt_c[g+1]),
      .rd_i        (rd_c[g]),
      .rd_o        (rd_c[g+1]),
      .hocc_i      (hocc_c[g]),
      .hocc_o      (hocc_c[g+1]),
      .sfx_i       (sfx_c[g+1]),
      .sfx_o       (sfx_c[g]),
      .prev_occ_i  (prev_occ),
      .prev_data_i (prev_data),
      .data_o      (data_w[g]),
      .occ_o       (occ_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (accept) begin
        ctl_q.exec  <= 1'b1;
        ctl_q.wr    <= (req_i.req_type == REQ_WRITE) & in_range;
        ctl_q.ins   <= (req_i.req_type == REQ_INSERT) & in_range;
        ctl_q.shift <= slot_occ;
        ctl_q.word  <= req_i.value;
        case (req_i.req_type)
          REQ_READ: begin
            valid_q <= 1'b1;
          end
          REQ_WRITE: begin
            valid_q <= in_range & ~slot_occ;
          end
          default: begin
            valid_q <= 1'b0;
          end
        endcase
      end else begin
        ctl_q.exec <= 1'b0;
        valid_q    <= 1'b0;
      end
    end
  end

  // response word needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (req_i.req_type == REQ_READ) begin
        rsp_q.kind <= KIND_READ;
        rsp_q.data <= rd_c[DEPTH];
      end else begin
        rsp_q.kind <= KIND_NOTICE;
        rsp_q.data <= '0;
      end
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  `IAS_ASSERT(a_valid_after_accept, clk_i, rst_ni, valid_o |-> $past(start && !busy))
  `IAS_ASSERT(a_busy_one_cycle, clk_i, rst_ni, busy |=> !busy)
  `IAS_ASSERT(a_read_answers, clk_i, rst_ni, (start && !busy && req_i.req_type == REQ_READ) |=> (valid_o && rsp_o.kind == KIND_READ))
  `IAS_NEVER(a_notice_zero, clk_i, rst_ni, valid_o && rsp_o.kind == KIND_NOTICE && rsp_o.data != '0)

endmodule
